// ===== rtl/foc_spd_pkg.sv =====
// foc_spd_pkg: shared widths, fixed-point constants, register codes and types
// for the sinusoidal pwm duty pipeline. no dependencies.

package foc_spd_pkg;

    localparam int PHASE_BITS_DEF      = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int DUTY_MAX_DEF        = 255;

    localparam int Q_W     = 16;
    localparam int ANG_W   = 16;
    localparam int SUP_W   = 16;
    localparam int DUTY_W  = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam int MAG_W   = 17;
    localparam int SIN_W   = 18;
    localparam int FRAC    = 16;
    localparam int PROD_W  = 34;
    localparam int U_W     = 52;
    localparam int M_W     = 41;
    localparam int M_SHIFT = 8;
    localparam int N_SHIFT = 25;
    localparam int HALF_SHIFT = 32;
    localparam int FULL_SHIFT = 33;
    localparam int ALPHA_A_SHIFT  = 17;
    localparam int ALPHA_BC_SHIFT = 16;

    localparam int X_MAX     = 65536;
    localparam int POLY_C1   = 102944;
    localparam int POLY_C2   = 42334;
    localparam int POLY_C3   = 5223;
    localparam int SQRT3_Q16 = 113512;

    localparam logic [SUP_W-1:0] SUPPLY_RESET = 16'd3072;
    localparam logic [ANG_W-1:0] OFFSET_RESET = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUPPLY = 1'b0,
        REG_OFFSET = 1'b1
    } t_reg_idx;

    typedef logic [MAG_W-1:0]        t_mag;
    typedef logic signed [SIN_W-1:0] t_sin;

    typedef struct packed {
        logic       zero_v;
        logic [2:0] low;
        logic [2:0] high;
    } t_duty_flags;

endpackage

// ===== rtl/foc_spd_phase.sv =====
// foc_spd_phase: offset add with phase wrap, then quarter-wave arguments
// for sine and cosine. two register stages. depends on foc_spd_pkg.

module foc_spd_phase #(
    parameter int PHASE_BITS      = foc_spd_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = foc_spd_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [foc_spd_pkg::Q_W-1:0]  i_q,
    input  logic [foc_spd_pkg::ANG_W-1:0]       i_angle,
    input  logic [foc_spd_pkg::ANG_W-1:0]       i_offset,
    output logic                                o_valid,
    output logic signed [foc_spd_pkg::Q_W-1:0]  o_q,
    output foc_spd_pkg::t_mag [1:0]             o_x,
    output logic [1:0]                          o_neg
);
    import foc_spd_pkg::*;

    localparam int SUM_W     = ANG_W + 1;
    localparam int WIDE_W    = PHASE_BITS + SINE_TABLE_BITS;
    localparam int PH_DOWN   = (PHASE_BITS > SINE_TABLE_BITS) ? (PHASE_BITS - SINE_TABLE_BITS) : 0;
    localparam int PH_UP     = (SINE_TABLE_BITS > PHASE_BITS) ? (SINE_TABLE_BITS - PHASE_BITS) : 0;
    localparam int QUAD_BITS = SINE_TABLE_BITS - 2;
    localparam int R_W       = QUAD_BITS + 1;
    localparam int X_SHIFT   = MAG_W + 1 - SINE_TABLE_BITS;

    logic [1:0]                    r_valid;
    logic [PHASE_BITS-1:0]         r_phase;
    logic signed [Q_W-1:0]         r_qa;
    logic signed [Q_W-1:0]         r_qb;
    t_mag [1:0]                    r_x;
    logic [1:0]                    r_neg;

    logic [SUM_W-1:0]              sum;
    logic [PHASE_BITS-1:0]         n_phase;
    logic [WIDE_W-1:0]             wide;
    logic [1:0][SINE_TABLE_BITS-1:0] idx;
    logic [1:0][1:0]               quad;
    logic [1:0][R_W-1:0]           rr;
    t_mag [1:0]                    n_x;
    logic [1:0]                    n_neg;

    always_comb begin
        sum     = SUM_W'(i_angle) + SUM_W'(i_offset);
        n_phase = PHASE_BITS'(sum);
        wide    = WIDE_W'(r_phase);
        idx[0]  = SINE_TABLE_BITS'((wide >> PH_DOWN) << PH_UP);
        idx[1]  = idx[0] + SINE_TABLE_BITS'(2 ** QUAD_BITS);
        for (int k = 0; k < 2; k++) begin
            quad[k] = idx[k][SINE_TABLE_BITS-1 -: 2];
            rr[k]   = R_W'(idx[k][QUAD_BITS-1:0]);
            if (quad[k][0]) begin
                rr[k] = R_W'(2 ** QUAD_BITS) - rr[k];
            end
            n_x[k]   = MAG_W'(rr[k]) << X_SHIFT;
            n_neg[k] = quad[k][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase <= n_phase;
            r_qa    <= i_q;
            r_qb    <= r_qa;
            r_x     <= n_x;
            r_neg   <= n_neg;
        end
    end

    assign o_valid = r_valid[1];
    assign o_q     = r_qb;
    assign o_x     = r_x;
    assign o_neg   = r_neg;

endmodule

// ===== rtl/foc_spd_trig.sv =====
// foc_spd_trig: quarter-wave sine polynomial for the sine and cosine lanes,
// one multiply per stage over four stages. depends on foc_spd_pkg.

module foc_spd_trig (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [foc_spd_pkg::Q_W-1:0]  i_q,
    input  foc_spd_pkg::t_mag [1:0]             i_x,
    input  logic [1:0]                          i_neg,
    output logic                                o_valid,
    output logic signed [foc_spd_pkg::Q_W-1:0]  o_q,
    output foc_spd_pkg::t_sin                   o_sin,
    output foc_spd_pkg::t_sin                   o_cos
);
    import foc_spd_pkg::*;

    localparam int MUL_W = 2 * MAG_W;
    localparam int T1_W  = 16;

    logic [3:0]              r_valid;
    logic signed [Q_W-1:0]   r1_q, r2_q, r3_q, r4_q;
    t_mag [1:0]              r1_x, r1_x2, r2_x, r2_x2, r3_x, r3_t2;
    logic [1:0][T1_W-1:0]    r2_t1;
    logic [1:0]              r1_neg, r2_neg, r3_neg;
    t_sin                    r4_s [2];

    logic [1:0][MUL_W-1:0]   p1, p2, p3, p4;
    t_mag [1:0]              n1_x2, n3_t2, mag;
    logic [1:0][T1_W-1:0]    n2_t1;
    logic [1:0][MAG_W:0]     s;
    t_sin                    n4_s [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            p1[k]    = MUL_W'(i_x[k]) * MUL_W'(i_x[k]);
            n1_x2[k] = p1[k][MAG_W+FRAC-1:FRAC];
            p2[k]    = MUL_W'(r1_x2[k]) * MUL_W'(POLY_C3);
            n2_t1[k] = T1_W'(POLY_C2) - p2[k][T1_W+FRAC-1:FRAC];
            p3[k]    = MUL_W'(r2_x2[k]) * MUL_W'(r2_t1[k]);
            n3_t2[k] = MAG_W'(POLY_C1) - p3[k][MAG_W+FRAC-1:FRAC];
            p4[k]    = MUL_W'(r3_x[k]) * MUL_W'(r3_t2[k]);
            s[k]     = p4[k][MAG_W+FRAC:FRAC];
            mag[k]   = (s[k] > (MAG_W+1)'(X_MAX)) ? MAG_W'(X_MAX) : s[k][MAG_W-1:0];
            n4_s[k]  = r3_neg[k] ? -SIN_W'(mag[k]) : SIN_W'(mag[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_q   <= i_q;
            r1_x   <= i_x;
            r1_x2  <= n1_x2;
            r1_neg <= i_neg;
            r2_q   <= r1_q;
            r2_x   <= r1_x;
            r2_x2  <= r1_x2;
            r2_t1  <= n2_t1;
            r2_neg <= r1_neg;
            r3_q   <= r2_q;
            r3_x   <= r2_x;
            r3_t2  <= n3_t2;
            r3_neg <= r2_neg;
            r4_q   <= r3_q;
            r4_s   <= n4_s;
        end
    end

    assign o_valid = r_valid[3];
    assign o_q     = r4_q;
    assign o_sin   = r4_s[0];
    assign o_cos   = r4_s[1];

endmodule

// ===== rtl/foc_spd_volt.sv =====
// foc_spd_volt: inverse park and clarke, half-supply bias, range flags and
// the scaled numerator for the duty divide. depends on foc_spd_pkg.

module foc_spd_volt #(
    parameter int DUTY_MAX = foc_spd_pkg::DUTY_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [foc_spd_pkg::Q_W-1:0]  i_q,
    input  foc_spd_pkg::t_sin                   i_sin,
    input  foc_spd_pkg::t_sin                   i_cos,
    input  logic [foc_spd_pkg::SUP_W-1:0]       i_supply,
    output logic                                o_valid,
    output logic [2:0][$clog2(DUTY_MAX)+foc_spd_pkg::SUP_W-1:0] o_num,
    output foc_spd_pkg::t_duty_flags            o_flags
);
    import foc_spd_pkg::*;

    localparam int QW  = $clog2(DUTY_MAX);
    localparam int NPW = QW + SUP_W;
    localparam int DW  = $clog2(DUTY_MAX + 1);
    localparam int NW  = M_W + DW;
    localparam logic signed [SIN_W-1:0] SQRT3_S = SIN_W'(SQRT3_Q16);

    logic [3:0]                 r_valid;
    logic signed [PROD_W-1:0]   r1_alpha, r1_beta, r2_alpha;
    logic signed [U_W-1:0]      r2_sb;
    logic signed [U_W-1:0]      r3_u [3];
    logic [2:0][NPW-1:0]        r4_num;
    t_duty_flags                r4_flags;

    logic signed [PROD_W-1:0]   n1_alpha, n1_beta;
    logic signed [U_W-1:0]      n2_sb;
    logic signed [U_W-1:0]      alpha_e, half, full;
    logic signed [U_W-1:0]      n3_u [3];
    logic [2:0][M_W-1:0]        m;
    logic [2:0][NW-1:0]         nprod;
    logic [2:0][NPW-1:0]        n4_num;
    t_duty_flags                n4_flags;

    always_comb begin
        n1_alpha = -(i_q * i_sin);
        n1_beta  = i_q * i_cos;
        n2_sb    = r1_beta * SQRT3_S;
        alpha_e  = U_W'(r2_alpha);
        half     = $signed({4'b0, i_supply, {HALF_SHIFT{1'b0}}});
        full     = $signed({3'b0, i_supply, {FULL_SHIFT{1'b0}}});
        n3_u[0]  = (alpha_e <<< ALPHA_A_SHIFT) + half;
        n3_u[1]  = r2_sb - (alpha_e <<< ALPHA_BC_SHIFT) + half;
        n3_u[2]  = -(alpha_e <<< ALPHA_BC_SHIFT) - r2_sb + half;
        n4_flags.zero_v = (i_supply == '0);
        for (int k = 0; k < 3; k++) begin
            n4_flags.low[k]  = r3_u[k][U_W-1] || (r3_u[k] == '0);
            n4_flags.high[k] = (r3_u[k] >= full);
            m[k]      = r3_u[k][M_W+M_SHIFT-1:M_SHIFT];
            nprod[k]  = NW'(m[k]) * NW'(DUTY_MAX);
            n4_num[k] = NPW'(nprod[k] >> N_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_alpha <= n1_alpha;
            r1_beta  <= n1_beta;
            r2_alpha <= r1_alpha;
            r2_sb    <= n2_sb;
            r3_u     <= n3_u;
            r4_num   <= n4_num;
            r4_flags <= n4_flags;
        end
    end

    assign o_valid = r_valid[3];
    assign o_num   = r4_num;
    assign o_flags = r4_flags;

endmodule

// ===== rtl/foc_spd_div.sv =====
// foc_spd_div: restoring divide of the scaled numerator by the supply, one
// quotient bit per stage, three lanes side by side. depends on foc_spd_pkg.

module foc_spd_div #(
    parameter int DUTY_MAX = foc_spd_pkg::DUTY_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [2:0][$clog2(DUTY_MAX)+foc_spd_pkg::SUP_W-1:0] i_num,
    input  foc_spd_pkg::t_duty_flags            i_flags,
    input  logic [foc_spd_pkg::SUP_W-1:0]       i_supply,
    output logic                                o_valid,
    output logic [2:0][$clog2(DUTY_MAX)-1:0]    o_quo,
    output foc_spd_pkg::t_duty_flags            o_flags
);
    import foc_spd_pkg::*;

    localparam int QW  = $clog2(DUTY_MAX);
    localparam int NPW = QW + SUP_W;

    logic [QW-1:0]               r_vld;
    t_duty_flags                 r_flg [QW];
    logic [2:0][SUP_W-1:0]       r_rem [QW];
    logic [2:0][QW-1:0]          r_num [QW];
    logic [2:0][QW-1:0]          r_quo [QW];

    logic [QW:0]                 p_vld;
    t_duty_flags                 p_flg [QW+1];
    logic [2:0][SUP_W-1:0]       p_rem [QW+1];
    logic [2:0][QW-1:0]          p_num [QW+1];
    logic [2:0][QW-1:0]          p_quo [QW+1];

    logic [2:0][SUP_W-1:0]       n_rem [QW];
    logic [2:0][QW-1:0]          n_num [QW];
    logic [2:0][QW-1:0]          n_quo [QW];

    always_comb begin
        logic [SUP_W:0] t;
        logic           ge;
        p_vld[0] = i_valid;
        p_flg[0] = i_flags;
        for (int k = 0; k < 3; k++) begin
            p_rem[0][k] = i_num[k][NPW-1:QW];
            p_num[0][k] = i_num[k][QW-1:0];
            p_quo[0][k] = '0;
        end
        for (int j = 1; j <= QW; j++) begin
            p_vld[j] = r_vld[j-1];
            p_flg[j] = r_flg[j-1];
            p_rem[j] = r_rem[j-1];
            p_num[j] = r_num[j-1];
            p_quo[j] = r_quo[j-1];
        end
        for (int j = 0; j < QW; j++) begin
            for (int k = 0; k < 3; k++) begin
                t  = {p_rem[j][k], p_num[j][k][QW-1]};
                ge = (t >= {1'b0, i_supply});
                n_rem[j][k] = ge ? SUP_W'(t - {1'b0, i_supply}) : t[SUP_W-1:0];
                n_num[j][k] = p_num[j][k] << 1;
                n_quo[j][k] = {p_quo[j][k][QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= p_vld[QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < QW; j++) begin
                r_flg[j] <= p_flg[j];
                r_rem[j] <= n_rem[j];
                r_num[j] <= n_num[j];
                r_quo[j] <= n_quo[j];
            end
        end
    end

    assign o_valid = p_vld[QW];
    assign o_flags = p_flg[QW];
    assign o_quo   = p_quo[QW];

endmodule

// ===== rtl/foc_sine_pwm_duty.sv =====
// foc_sine_pwm_duty: top level of the sinusoidal pwm duty pipeline with
// config registers, input skid stage and output register.
// depends on foc_spd_pkg, foc_spd_phase, foc_spd_trig, foc_spd_volt, foc_spd_div.
//
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         q_voltage, electrical_angle
//   m_axis    out  tvalid/tready         duty_a, duty_b, duty_c
//   cfg       in   i_cfg_we              i_cfg_index, i_cfg_wdata
//
// one beat per cycle sustained when the output is not stalled; data passes
// through phase, the four-multiply sine polynomial, voltage and one divide stage
// per quotient bit. synchronous active-low reset clears valids and config.
// an output stall freezes the whole pipeline; the skid stage still takes one
// beat, so s_axis_tready drops only once both it and the output are full.

module foc_sine_pwm_duty #(
    parameter int PHASE_BITS      = foc_spd_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = foc_spd_pkg::SINE_TABLE_BITS_DEF,
    parameter int DUTY_MAX        = foc_spd_pkg::DUTY_MAX_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // q_voltage [15:0], electrical_angle [31:16]
    input  logic [foc_spd_pkg::Q_W+foc_spd_pkg::ANG_W-1:0] s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // duty_a [7:0], duty_b [15:8], duty_c [23:16]
    output logic [3*foc_spd_pkg::DUTY_W-1:0]        m_axis_tdata,
    input  logic                                    i_cfg_we,
    input  logic [foc_spd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [foc_spd_pkg::CFG_W-1:0]           i_cfg_wdata
);
    import foc_spd_pkg::*;

    localparam int IN_W = Q_W + ANG_W;
    localparam int QW   = $clog2(DUTY_MAX);
    localparam int NPW  = QW + SUP_W;
    localparam logic [DUTY_W-1:0] DUTY_SAT = DUTY_W'(DUTY_MAX);

    logic [SUP_W-1:0]        r_supply;
    logic [ANG_W-1:0]        r_offset;
    logic                    r_skid_valid;
    logic [IN_W-1:0]         r_skid_data;
    logic                    r_out_valid;
    logic [3*DUTY_W-1:0]     r_out_data;

    logic                    en;
    logic                    pipe_valid;
    logic [IN_W-1:0]         pipe_data;
    logic                    n_skid_valid;
    logic                    skid_load;

    logic                    ph_valid;
    logic signed [Q_W-1:0]   ph_q;
    t_mag [1:0]              ph_x;
    logic [1:0]              ph_neg;

    logic                    tr_valid;
    logic signed [Q_W-1:0]   tr_q;
    t_sin                    tr_sin, tr_cos;

    logic                    vo_valid;
    logic [2:0][NPW-1:0]     vo_num;
    t_duty_flags             vo_flags;

    logic                    dv_valid;
    logic [2:0][QW-1:0]      dv_quo;
    t_duty_flags             dv_flags;

    logic [3*DUTY_W-1:0]     n_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= SUPPLY_RESET;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SUPPLY: r_supply <= SUP_W'(i_cfg_wdata);
                REG_OFFSET: r_offset <= ANG_W'(i_cfg_wdata);
            endcase
        end
    end

    always_comb begin
        en            = !r_out_valid || m_axis_tready;
        s_axis_tready = !r_skid_valid || en;
        pipe_valid    = r_skid_valid || s_axis_tvalid;
        pipe_data     = r_skid_valid ? r_skid_data : s_axis_tdata;
        n_skid_valid  = en ? (r_skid_valid && s_axis_tvalid) : (r_skid_valid || s_axis_tvalid);
        skid_load     = s_axis_tvalid && s_axis_tready && (!en || r_skid_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else begin
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (skid_load) begin
            r_skid_data <= s_axis_tdata;
        end
    end

    foc_spd_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (pipe_valid),
        .i_q      ($signed(pipe_data[Q_W-1:0])),
        .i_angle  (pipe_data[IN_W-1:Q_W]),
        .i_offset (r_offset),
        .o_valid  (ph_valid),
        .o_q      (ph_q),
        .o_x      (ph_x),
        .o_neg    (ph_neg)
    );

    foc_spd_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ph_valid),
        .i_q     (ph_q),
        .i_x     (ph_x),
        .i_neg   (ph_neg),
        .o_valid (tr_valid),
        .o_q     (tr_q),
        .o_sin   (tr_sin),
        .o_cos   (tr_cos)
    );

    foc_spd_volt #(
        .DUTY_MAX (DUTY_MAX)
    ) u_volt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (tr_valid),
        .i_q      (tr_q),
        .i_sin    (tr_sin),
        .i_cos    (tr_cos),
        .i_supply (r_supply),
        .o_valid  (vo_valid),
        .o_num    (vo_num),
        .o_flags  (vo_flags)
    );

    foc_spd_div #(
        .DUTY_MAX (DUTY_MAX)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (vo_valid),
        .i_num    (vo_num),
        .i_flags  (vo_flags),
        .i_supply (r_supply),
        .o_valid  (dv_valid),
        .o_quo    (dv_quo),
        .o_flags  (dv_flags)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (dv_flags.zero_v || dv_flags.low[k]) begin
                n_out_data[k*DUTY_W +: DUTY_W] = '0;
            end else if (dv_flags.high[k]) begin
                n_out_data[k*DUTY_W +: DUTY_W] = DUTY_SAT;
            end else begin
                n_out_data[k*DUTY_W +: DUTY_W] = DUTY_W'(dv_quo[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
